/* hw/rtl/emgf_pkg.sv */
// ----------------------------------------------------------------------------
// emgf_pkg
// Types, constants and helper functions of the envelope filter chain.
// ----------------------------------------------------------------------------
package emgf_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int LIMIT_W   = 23;
  localparam int VAL_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int SHIFT     = 16;          // internal minus sample fraction bits
  localparam int COEF_FRAC = 40;
  localparam int OPND_W    = 50;          // magnitude of a biquad operand
  localparam int COEF_W    = 48;          // coefficient magnitude, digit padded
  localparam int DIGIT_W   = 8;
  localparam int N_DIGITS  = COEF_W / DIGIT_W;
  localparam int PROD_W    = 53;
  localparam int ACC_W     = 56;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_CH0   = 3'd0,
    REG_OFFSET_CH1   = 3'd1,
    REG_FIRST_CLIP   = 3'd2,
    REG_NOISE_GATE   = 3'd3,
    REG_SECOND_CLIP  = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_START,
    ST_WAIT,
    ST_POST
  } state_e;

  typedef enum logic [1:0] {
    STG_HP  = 2'd0,
    STG_LP1 = 2'd1,
    STG_LP2 = 2'd2
  } stage_e;

  typedef enum logic [1:0] {
    TERM_K  = 2'd0,
    TERM_A1 = 2'd1,
    TERM_A2 = 2'd2
  } term_e;

  typedef struct packed {
    val_t x0;
    val_t x1;
    val_t y0;
    val_t y1;
  } bq_hist_t;

  typedef bq_hist_t [2:0] hist_t;

  typedef struct packed {
    logic                start;
    logic [OPND_W-1:0]   a_mag;
    logic [COEF_W-1:0]   c_mag;
  } mul_req_t;

  typedef struct packed {
    logic                done;
    logic [PROD_W-1:0]   prod;
  } mul_rsp_t;

  localparam logic [63:0] DEC_SCALE = 64'd1000000000000000000;

  // round(n / 10^18 * 2^40)
  function automatic logic [COEF_W-1:0] coef_q40(input logic [63:0] n);
    logic [63:0] q;
    logic [63:0] r;
    q = (n >= DEC_SCALE) ? 64'd1 : 64'd0;
    r = (n >= DEC_SCALE) ? n - DEC_SCALE : n;
    for (int b = 0; b <= COEF_FRAC; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= DEC_SCALE) begin
        r = r - DEC_SCALE;
        q = q | 64'd1;
      end
    end
    q = (q + 64'd1) >> 1;
    return q[COEF_W-1:0];
  endfunction

  localparam logic [COEF_W-1:0] COEF_MAG [9] = '{
    coef_q40(64'd43134450881076000),   coef_q40(64'd171901801714236000),
    coef_q40(64'd282191837708290000),  coef_q40(64'd1998222847291842000),
    coef_q40(64'd998224425026401000),  coef_q40(64'd394433639694),
    coef_q40(64'd1783787708559230000), coef_q40(64'd804982594421399000),
    coef_q40(64'd897192575745157000)
  };

  localparam logic COEF_NEG [9] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                                    1'b1, 1'b0, 1'b0};

  // coefficient slot per stage and term: gain, a1, a2
  localparam logic [3:0] COEF_IDX [3][3] = '{
    '{4'd8, 4'd6, 4'd7},
    '{4'd2, 4'd0, 4'd1},
    '{4'd5, 4'd3, 4'd4}
  };

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  function automatic val_t sat48(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(VAL_MAX)) return VAL_MAX;
    if (v < ACC_W'(VAL_MIN)) return VAL_MIN;
    return VAL_W'(v);
  endfunction

  function automatic val_t mag48(input val_t v);
    if (v == VAL_MIN) return VAL_MAX;
    if (v < 0) return -v;
    return v;
  endfunction

endpackage

/* hw/rtl/emgf_if.sv */
// ----------------------------------------------------------------------------
// emgf channel interfaces
// Sample, envelope and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface emgf_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [emgf_pkg::SAMPLE_W-1:0]    sample;
  logic                                    channel;

  modport source (output valid, sample, channel, input ready);
  modport sink   (input valid, sample, channel, output ready);
endinterface

interface emgf_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [emgf_pkg::VAL_W-1:0]       envelope;
  logic                                    out_channel;

  modport source (output valid, envelope, out_channel, input ready);
  modport sink   (input valid, envelope, out_channel, output ready);
endinterface

interface emgf_cfg_if;
  logic                                    valid;
  logic                                    ready;
  logic [emgf_pkg::CFG_IDX_W-1:0]          index;
  logic [emgf_pkg::SAMPLE_W-1:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/emg_envelope_filter_chain.sv */
// ----------------------------------------------------------------------------
// emg_envelope_filter_chain
// Offset, high-pass biquad, clip, low-pass biquad, noise gate and clip,
// rectify and smoothing low-pass biquad, with history kept per channel.
//
//   channel   dir  handshake     payload
//   sample    in   valid/ready   sample, channel
//   envelope  out  valid/ready   envelope, out_channel
//   cfg       in   valid/ready   index, data (ready always high)
//
// Each accepted sample passes a load step, then 3 biquads of 3 products and
// an update each; a product is a start step, six 8-bit coefficient digits
// and a collect step. Input is taken only in idle, so no new word is taken
// before the previous one is done. A finished envelope waits in the output
// register while the next sample is taken; the last update stalls only if
// that register is full. Reset clears the history and loads register defaults.
// ----------------------------------------------------------------------------
module emg_envelope_filter_chain #(
  parameter int CHANNELS = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  emgf_in_if.sink            sample_if_i,
  emgf_out_if.source         envelope_if_o,
  emgf_cfg_if.sink           cfg_if_i
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  emgf_pkg::state_e  state_q, state_d;
  emgf_pkg::stage_e  stage_q;
  emgf_pkg::term_e   term_q;

  logic signed [emgf_pkg::SAMPLE_W-1:0] offset0_q, offset1_q, sample_q;
  logic [emgf_pkg::LIMIT_W-1:0]         clip1_q, gate_q, clip2_q;
  logic                                 ch_q;
  logic [IDX_W-1:0]                     ch_idx;

  emgf_pkg::hist_t   hist_rd, wk_q, wk_upd;
  emgf_pkg::val_t    x0_q, y_sat, mag_y, nx;
  logic signed [emgf_pkg::ACC_W-1:0] acc_q, prod_s;
  logic              prod_neg_q;

  logic              out_valid_q, out_ch_q;
  emgf_pkg::val_t    env_q;

  logic              in_acc, load_en, start_en, acc_en, adv_en, finish_en;
  logic signed [emgf_pkg::SAMPLE_W:0] sum_in;
  emgf_pkg::val_t    v_in;
  logic signed [emgf_pkg::OPND_W:0]   opnd, ex0, eh0, eh1;
  logic [3:0]        cidx;
  logic [emgf_pkg::VAL_W-1:0] lim1, lim_gate, lim2;

  emgf_pkg::mul_req_t mreq;
  emgf_pkg::mul_rsp_t mrsp;

  // ---------------- configuration ----------------
  assign cfg_if_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset0_q <= '0;
      offset1_q <= '0;
      clip1_q   <= 23'd131072;
      gate_q    <= 23'd1311;
      clip2_q   <= 23'd98304;
    end else if (cfg_if_i.valid) begin
      unique case (cfg_if_i.index)
        emgf_pkg::REG_OFFSET_CH0:  offset0_q <= cfg_if_i.data;
        emgf_pkg::REG_OFFSET_CH1:  offset1_q <= cfg_if_i.data;
        emgf_pkg::REG_FIRST_CLIP:  clip1_q   <= cfg_if_i.data[emgf_pkg::LIMIT_W-1:0];
        emgf_pkg::REG_NOISE_GATE:  gate_q    <= cfg_if_i.data[emgf_pkg::LIMIT_W-1:0];
        emgf_pkg::REG_SECOND_CLIP: clip2_q   <= cfg_if_i.data[emgf_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  assign in_acc            = sample_if_i.valid && sample_if_i.ready;
  assign sample_if_i.ready = (state_q == emgf_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= emgf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    load_en   = 1'b0;
    start_en  = 1'b0;
    acc_en    = 1'b0;
    adv_en    = 1'b0;
    finish_en = 1'b0;
    unique case (state_q)
      emgf_pkg::ST_IDLE: begin
        if (in_acc) state_d = emgf_pkg::ST_LOAD;
      end
      emgf_pkg::ST_LOAD: begin
        load_en = 1'b1;
        state_d = emgf_pkg::ST_START;
      end
      emgf_pkg::ST_START: begin
        start_en = 1'b1;
        state_d  = emgf_pkg::ST_WAIT;
      end
      emgf_pkg::ST_WAIT: begin
        if (mrsp.done) begin
          acc_en  = 1'b1;
          state_d = (term_q == emgf_pkg::TERM_A2) ? emgf_pkg::ST_POST : emgf_pkg::ST_START;
        end
      end
      emgf_pkg::ST_POST: begin
        if (stage_q != emgf_pkg::STG_LP2) begin
          adv_en  = 1'b1;
          state_d = emgf_pkg::ST_START;
        end else if (!out_valid_q || envelope_if_o.ready) begin
          finish_en = 1'b1;
          state_d   = emgf_pkg::ST_IDLE;
        end
      end
      default: state_d = emgf_pkg::ST_IDLE;
    endcase
  end

  // ---------------- datapath ----------------
  assign ch_idx = (CHANNELS > 1) ? IDX_W'(ch_q) : '0;
  assign sum_in = (emgf_pkg::SAMPLE_W+1)'(sample_q)
                + (emgf_pkg::SAMPLE_W+1)'(ch_q ? offset1_q : offset0_q);
  assign v_in   = emgf_pkg::val_t'(sum_in) <<< emgf_pkg::SHIFT;

  assign ex0 = (emgf_pkg::OPND_W+1)'(x0_q);
  assign eh0 = (emgf_pkg::OPND_W+1)'(wk_q[stage_q].x0);
  assign eh1 = (emgf_pkg::OPND_W+1)'(wk_q[stage_q].x1);

  always_comb begin
    unique case (term_q)
      emgf_pkg::TERM_K:  opnd = (stage_q == emgf_pkg::STG_HP) ? ex0 - (eh0 <<< 1) + eh1
                                                             : ex0 + (eh0 <<< 1) + eh1;
      emgf_pkg::TERM_A1: opnd = (emgf_pkg::OPND_W+1)'(wk_q[stage_q].y0);
      emgf_pkg::TERM_A2: opnd = (emgf_pkg::OPND_W+1)'(wk_q[stage_q].y1);
      default:           opnd = '0;
    endcase
  end

  assign cidx        = emgf_pkg::COEF_IDX[stage_q][term_q];
  assign mreq.start  = start_en;
  assign mreq.a_mag  = opnd[emgf_pkg::OPND_W] ? emgf_pkg::OPND_W'(-opnd)
                                              : emgf_pkg::OPND_W'(opnd);
  assign mreq.c_mag  = emgf_pkg::COEF_MAG[cidx];

  assign prod_s = signed'(emgf_pkg::ACC_W'(mrsp.prod));

  assign lim1     = emgf_pkg::VAL_W'({clip1_q, {emgf_pkg::SHIFT{1'b0}}});
  assign lim_gate = emgf_pkg::VAL_W'({gate_q,  {emgf_pkg::SHIFT{1'b0}}});
  assign lim2     = emgf_pkg::VAL_W'({clip2_q, {emgf_pkg::SHIFT{1'b0}}});

  assign y_sat = emgf_pkg::sat48(acc_q);
  assign mag_y = emgf_pkg::mag48(y_sat);

  always_comb begin
    nx = '0;
    unique case (stage_q)
      emgf_pkg::STG_HP:  nx = ($unsigned(mag_y) > lim1) ? '0 : y_sat;
      emgf_pkg::STG_LP1: nx = ($unsigned(mag_y) < lim_gate || $unsigned(mag_y) > lim2)
                              ? '0 : mag_y;
      default:           nx = y_sat;
    endcase
  end

  always_comb begin
    wk_upd = wk_q;
    wk_upd[stage_q].x1 = wk_q[stage_q].x0;
    wk_upd[stage_q].x0 = x0_q;
    wk_upd[stage_q].y1 = wk_q[stage_q].y0;
    wk_upd[stage_q].y0 = y_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= emgf_pkg::STG_HP;
      term_q  <= emgf_pkg::TERM_K;
    end else if (load_en || adv_en) begin
      stage_q <= load_en ? emgf_pkg::STG_HP
               : (stage_q == emgf_pkg::STG_HP) ? emgf_pkg::STG_LP1 : emgf_pkg::STG_LP2;
      term_q  <= emgf_pkg::TERM_K;
    end else if (acc_en) begin
      unique case (term_q)
        emgf_pkg::TERM_K:  term_q <= emgf_pkg::TERM_A1;
        emgf_pkg::TERM_A1: term_q <= emgf_pkg::TERM_A2;
        default:           term_q <= emgf_pkg::TERM_K;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_if_i.sample;
      ch_q     <= sample_if_i.channel;
    end
    if (load_en) begin
      wk_q  <= hist_rd;
      x0_q  <= v_in;
      acc_q <= '0;
    end else if (adv_en) begin
      wk_q  <= wk_upd;
      x0_q  <= nx;
      acc_q <= '0;
    end else if (acc_en) begin
      acc_q <= prod_neg_q ? acc_q - prod_s : acc_q + prod_s;
    end
    // product sign: operand, coefficient, and feedback terms subtract
    if (start_en) begin
      prod_neg_q <= opnd[emgf_pkg::OPND_W] ^ emgf_pkg::COEF_NEG[cidx]
                    ^ (term_q != emgf_pkg::TERM_K);
    end
  end

  emgf_digit_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  emgf_hist #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (ch_idx),
    .rd_data_o (hist_rd),
    .wr_en_i   (finish_en),
    .wr_idx_i  (ch_idx),
    .wr_data_i (wk_upd)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish_en) begin
      out_valid_q <= 1'b1;
    end else if (envelope_if_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_en) begin
      env_q    <= y_sat;
      out_ch_q <= ch_q;
    end
  end

  assign envelope_if_o.valid       = out_valid_q;
  assign envelope_if_o.envelope    = env_q;
  assign envelope_if_o.out_channel = out_ch_q;

`ifndef ASSERT_OFF
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mrsp.done |-> state_q == emgf_pkg::ST_WAIT)
    else $error("multiplier finished outside the wait state");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == emgf_pkg::ST_LOAD)
    else $error("accepted word did not start a load");

  a_out_from_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == emgf_pkg::ST_POST
                         && $past(stage_q) == emgf_pkg::STG_LP2)
    else $error("envelope raised without finishing the last biquad");
`endif

endmodule

/* hw/rtl/emgf_digit_mul.sv */
// ----------------------------------------------------------------------------
// emgf_digit_mul
// Digit-serial multiplier: operand magnitude times coefficient magnitude,
// one coefficient digit per cycle, result rounded by 2^-40 half up.
// ----------------------------------------------------------------------------
module emgf_digit_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  emgf_pkg::mul_req_t  req_i,
  output emgf_pkg::mul_rsp_t  rsp_o
);

  localparam int HI_W  = emgf_pkg::OPND_W + 1;
  localparam int SUM_W = HI_W + emgf_pkg::DIGIT_W;
  localparam int CNT_W = $clog2(emgf_pkg::N_DIGITS);

  logic                              busy_q, done_q;
  logic [CNT_W-1:0]                  cnt_q;
  logic [emgf_pkg::OPND_W-1:0]       a_q;
  logic [emgf_pkg::COEF_W-1:0]       c_q;
  logic [HI_W-1:0]                   hi_q;
  logic [emgf_pkg::COEF_W-1:0]       lo_q;
  logic [SUM_W-1:0]                  sum_d;
  logic [emgf_pkg::COEF_W:0]         rnd_t;

  assign sum_d = SUM_W'(hi_q) + SUM_W'(a_q) * SUM_W'(c_q[emgf_pkg::DIGIT_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(emgf_pkg::N_DIGITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q  <= req_i.a_mag;
      c_q  <= req_i.c_mag;
      hi_q <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      hi_q <= sum_d[SUM_W-1:emgf_pkg::DIGIT_W];
      lo_q <= {sum_d[emgf_pkg::DIGIT_W-1:0], lo_q[emgf_pkg::COEF_W-1:emgf_pkg::DIGIT_W]};
      c_q  <= c_q >> emgf_pkg::DIGIT_W;
    end
  end

  // low word plus half an lsb of the result decides the round-up
  assign rnd_t = {1'b0, lo_q} + (49'd1 << (emgf_pkg::COEF_FRAC - 1));

  assign rsp_o.done = done_q;
  assign rsp_o.prod = {hi_q[emgf_pkg::PROD_W-emgf_pkg::COEF_W+emgf_pkg::COEF_FRAC-1:0],
                       {(emgf_pkg::COEF_W-emgf_pkg::COEF_FRAC){1'b0}}}
                    + emgf_pkg::PROD_W'(rnd_t[emgf_pkg::COEF_W:emgf_pkg::COEF_FRAC]);

endmodule

/* hw/rtl/emgf_hist.sv */
// ----------------------------------------------------------------------------
// emgf_hist
// Per-channel filter history: two inputs and two outputs of each biquad.
// ----------------------------------------------------------------------------
module emgf_hist #(
  parameter int CHANNELS = 2,
  parameter int IDX_W    = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [IDX_W-1:0]    rd_idx_i,
  output emgf_pkg::hist_t     rd_data_o,
  input  logic                wr_en_i,
  input  logic [IDX_W-1:0]    wr_idx_i,
  input  emgf_pkg::hist_t     wr_data_i
);

  emgf_pkg::hist_t mem_q [CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        mem_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_idx_i];

endmodule
